>>> design/bmfns_pkg.sv
package bmfns_pkg;

   // search pointer and offset widths (fixed by the 11-bit position)
   localparam int PtrWidth = 6;
   localparam int OffWidth = 6;
   localparam int PosWidth = 11;

   // item opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_FIND  = 1'b1;

   // lane masks for the lowest-bit encoder
   localparam logic [63:0] MaskLo32 = 64'h0000_0000_ffff_ffff;
   localparam logic [63:0] MaskLo16 = 64'h0000_ffff_0000_ffff;
   localparam logic [63:0] MaskLo8  = 64'h00ff_00ff_00ff_00ff;
   localparam logic [63:0] MaskLo4  = 64'h0f0f_0f0f_0f0f_0f0f;
   localparam logic [63:0] MaskLo2  = 64'h3333_3333_3333_3333;
   localparam logic [63:0] MaskLo1  = 64'h5555_5555_5555_5555;

   // controller to datapath
   typedef struct packed {
      logic clear_en;
      logic load_find;
      logic write_en;
      logic advance;
      logic save_result;
      logic emit;
   } bmfns_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic cur_valid;
      logic word_nonzero;
      logic out_free;
   } bmfns_sts_type;

   // position of the lowest set bit of a nonzero word
   function automatic logic [5:0] low_bit_pos(input logic [63:0] v);
      logic [63:0] one;
      logic [5:0]  pos;
      one = v & (~v + 64'd1);
      pos = 6'd63;
      if (|(one & MaskLo32)) pos = pos - 6'd32;
      if (|(one & MaskLo16)) pos = pos - 6'd16;
      if (|(one & MaskLo8))  pos = pos - 6'd8;
      if (|(one & MaskLo4))  pos = pos - 6'd4;
      if (|(one & MaskLo2))  pos = pos - 6'd2;
      if (|(one & MaskLo1))  pos = pos - 6'd1;
      return pos;
   endfunction

endpackage

>>> design/bmfns_ctrl.sv
module bmfns_ctrl
   import bmfns_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_opcode,
   output logic          req_stall,
   input  bmfns_sts_type sts,
   output bmfns_cmd_type cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // accept words only when idle
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_FIND) begin
                  cmd.load_find = 1'b1;
                  state_in      = ST_SCAN;
               end else begin
                  cmd.write_en = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (!sts.cur_valid || sts.word_nonzero) begin
               cmd.save_result = 1'b1;
               state_in        = ST_EMIT;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // no word may enter while the mask is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("word accepted during clear pass");

   // skip only an empty word inside the search range
   a_advance_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> (sts.cur_valid && !sts.word_nonzero))
      else $error("skipped a word that holds a hit");

   // a finished search always goes on to emit
   a_save_then_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.save_result |=> (state_ff == ST_EMIT))
      else $error("search result not emitted");

   // never overwrite a result still waiting on the output
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("output register overwritten");

endmodule

>>> design/bmfns_dpath.sv
module bmfns_dpath
   import bmfns_pkg::*;
#(
   parameter int MASK_WORDS = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  bmfns_cmd_type       cmd,
   output bmfns_sts_type       sts,
   input  logic [3:0]          req_word_index,
   input  logic [63:0]         req_word_data,
   input  logic [PosWidth-1:0] req_start_bit,
   input  logic                csr_valid,
   input  logic [PosWidth-1:0] csr_bits_in_use,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PosWidth-1:0] rsp_found_position,
   output logic                rsp_found
);

   localparam int AW  = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;
   localparam int Cap = MASK_WORDS * 64;

   logic [63:0]         mem [MASK_WORDS];
   logic [63:0]         rd_data_ff;
   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       wr_addr;
   logic [63:0]         wr_data;
   logic                wr_en;
   logic [AW-1:0]       clr_ff;
   logic [PosWidth-1:0] limit_ff;
   logic [PtrWidth-1:0] ptr_ff;
   logic [PtrWidth-1:0] ptr_in;
   logic [OffWidth-1:0] off_ff;
   logic [OffWidth-1:0] off_in;
   logic [31:0]         widx_wide;
   logic [31:0]         ptr_wide;
   logic [31:0]         start_word_wide;
   logic [31:0]         next_ptr_wide;
   logic [63:0]         masked;
   logic [PtrWidth+5:0] hit_pos;
   logic                hit_in_range;
   logic                res_found_ff;
   logic [PosWidth-1:0] res_pos_ff;
   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic [PosWidth-1:0] rsp_pos_ff;

   // size register, saturated to the storage
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_valid) begin
         if (32'(csr_bits_in_use) > Cap) limit_ff <= PosWidth'(Cap);
         else limit_ff <= csr_bits_in_use;
      end
   end

   // write port: clear pass or word store
   assign widx_wide = 32'(req_word_index);
   always_comb begin
      if (cmd.clear_en) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_en   = cmd.write_en && (widx_wide < MASK_WORDS);
         wr_addr = widx_wide[AW-1:0];
         wr_data = req_word_data;
      end
   end

   // clear counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end
   assign sts.clear_last = (32'(clr_ff) == MASK_WORDS - 1);

   // read port: start word on load, otherwise prefetch the next word
   assign start_word_wide = 32'(req_start_bit[PosWidth-1:OffWidth]);
   assign next_ptr_wide   = 32'(ptr_ff) + 32'd1;
   assign rd_addr = cmd.load_find ? start_word_wide[AW-1:0] : next_ptr_wide[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // search pointer
   always_comb begin
      ptr_in = ptr_ff;
      off_in = off_ff;
      if (cmd.load_find) begin
         ptr_in = PtrWidth'(req_start_bit[PosWidth-1:OffWidth]);
         off_in = req_start_bit[OffWidth-1:0];
      end else if (cmd.advance) begin
         ptr_in = ptr_ff + PtrWidth'(1);
         off_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      off_ff <= off_in;
   end

   // examine current word
   assign ptr_wide      = 32'(ptr_ff);
   assign sts.cur_valid = (ptr_wide < MASK_WORDS) &&
                          ({ptr_ff, off_ff} < {1'b0, limit_ff});
   assign masked           = rd_data_ff & ({64{1'b1}} << off_ff);
   assign sts.word_nonzero = |masked;
   assign hit_pos          = {ptr_ff, low_bit_pos(masked)};
   assign hit_in_range     = hit_pos < {1'b0, limit_ff};

   // hold the search outcome
   always_ff @(posedge clock) begin
      if (cmd.save_result) begin
         res_found_ff <= sts.cur_valid && sts.word_nonzero && hit_in_range;
         if (sts.cur_valid && sts.word_nonzero && hit_in_range) begin
            res_pos_ff <= hit_pos[PosWidth-1:0];
         end else begin
            res_pos_ff <= limit_ff;
         end
      end
   end

   // output register
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_found_ff <= res_found_ff;
         rsp_pos_ff   <= res_pos_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_pos_ff;

endmodule

>>> design/bitmask_find_next_set_unit.sv
// channel  | direction | handshake           | payload
// req_     | in        | req_valid/req_stall | opcode, word_index, word_data, start_bit
// rsp_     | out       | rsp_valid/rsp_stall | found_position, found
// csr_     | in        | csr_valid/csr_ready | bits_in_use
//
// A write word is stored when it is accepted. A find scans the mask words in order,
// one mask word per cycle from the registered memory port, until it meets a set bit or
// runs past the last word or the size; its result then waits while an earlier result
// still sits in the output register.
// After reset a clearing pass zeroes the mask word by word; req_stall is high meanwhile.
// The result sits in an output register; a new word is taken while it waits on rsp_stall.
// csr_ready is always high; size writes saturate to MASK_WORDS*64.
module bitmask_find_next_set_unit
   import bmfns_pkg::*;
#(
   parameter int MASK_WORDS = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [3:0]          req_word_index,
   input  logic [63:0]         req_word_data,
   input  logic [PosWidth-1:0] req_start_bit,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PosWidth-1:0] rsp_found_position,
   output logic                rsp_found,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [PosWidth-1:0] csr_bits_in_use
);

   bmfns_cmd_type cmd;
   bmfns_sts_type sts;

   assign csr_ready = 1'b1;

   bmfns_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   bmfns_dpath #(
      .MASK_WORDS (MASK_WORDS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_word_index     (req_word_index),
      .req_word_data      (req_word_data),
      .req_start_bit      (req_start_bit),
      .csr_valid          (csr_valid && csr_ready),
      .csr_bits_in_use    (csr_bits_in_use),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found_position (rsp_found_position),
      .rsp_found          (rsp_found)
   );

endmodule

>>> tb/tb_bitmask_find_next_set_unit.sv
module tb_bitmask_find_next_set_unit;
   import bmfns_pkg::*;

   localparam int MaskWords   = 16;
   localparam int MaxBits     = MaskWords * 64;
   localparam int SettleWait  = MaskWords + 8;
   localparam int StallLimit  = 3000;
   localparam int HoldOffLong = 150;
   localparam int PhaseItems  = 75;

   typedef struct packed {
      logic                opcode;
      logic [3:0]          word_index;
      logic [63:0]         word_data;
      logic [PosWidth-1:0] start_bit;
   } mask_request_type;

   typedef struct packed {
      logic [PosWidth-1:0] position;
      logic                found;
   } find_result_type;

   // mirror of the mask store and the size register; queue of pending finds
   class next_set_predictor_type;
      logic [63:0]         mask_word [MaskWords];
      logic [PosWidth-1:0] size_bits;
      find_result_type     expected_finds [$];
      int                  errors;

      function new();
         foreach (mask_word[i]) mask_word[i] = '0;
         size_bits = '0;
         errors    = 0;
      endfunction

      // clamp the size to what the store holds
      function void set_size(input logic [PosWidth-1:0] v);
         size_bits = (v > MaxBits) ? PosWidth'(MaxBits) : v;
      endfunction

      // lowest set bit at or above start and below the size in use
      function find_result_type search(input logic [PosWidth-1:0] start);
         find_result_type r;
         int unsigned     cur;
         int unsigned     w;
         int unsigned     b;
         int unsigned     i;
         logic [63:0]     bits;
         r.position = size_bits;
         r.found    = 1'b0;
         cur        = 32'(start);
         while (cur < size_bits && cur / 64 < MaskWords) begin
            w    = cur / 64;
            b    = cur % 64;
            bits = mask_word[w] & ~((64'd1 << b) - 64'd1);
            if (bits != '0) begin
               i = b;
               while (!bits[i]) i++;
               if (w * 64 + i < size_bits) begin
                  r.position = PosWidth'(w * 64 + i);
                  r.found    = 1'b1;
               end
               return r;
            end
            cur = (w + 1) * 64;
         end
         return r;
      endfunction

      // store a word, or queue the result of a find
      function void note_request(input mask_request_type item);
         if (item.opcode == OP_WRITE) begin
            if (item.word_index < MaskWords) mask_word[item.word_index] = item.word_data;
         end else begin
            expected_finds.push_back(search(item.start_bit));
         end
      endfunction

      task report_mismatch(input string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      // compare a returned word with the oldest pending find
      task check_find(input logic [PosWidth-1:0] position, input logic found);
         find_result_type want;
         if (expected_finds.size() == 0) begin
            report_mismatch($sformatf("unexpected result pos=%0d found=%0b", position, found));
         end else begin
            want = expected_finds.pop_front();
            if (position !== want.position)
               report_mismatch($sformatf("position got %0d want %0d", position, want.position));
            if (found !== want.found)
               report_mismatch($sformatf("found got %0b want %0b", found, want.found));
         end
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_opcode = OP_WRITE;
   logic [3:0]          req_word_index = '0;
   logic [63:0]         req_word_data = '0;
   logic [PosWidth-1:0] req_start_bit = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [PosWidth-1:0] rsp_found_position;
   logic                rsp_found;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [PosWidth-1:0] csr_bits_in_use = '0;

   next_set_predictor_type predictor = new();
   int                     send_idle_pct = 20;
   int                     rsp_idle_pct = 20;
   int                     rsp_hold_left = 0;

   bitmask_find_next_set_unit #(.MASK_WORDS(MaskWords)) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_word_index     (req_word_index),
      .req_word_data      (req_word_data),
      .req_start_bit      (req_start_bit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found_position (rsp_found_position),
      .rsp_found          (rsp_found),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_bits_in_use    (csr_bits_in_use)
   );

   always #2 clock = ~clock;

   // hold off the result side: random stalls, or a long stretch while a hold-off count runs
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // check each accepted result word
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
         predictor.check_find(rsp_found_position, rsp_found);
   end

   // end the run when no word moves on any channel for too long
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < StallLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL bitmask_find_next_set_unit");
      $finish;
   end

   function automatic mask_request_type make_request(input logic op, input logic [3:0] idx,
                                                     input logic [63:0] data,
                                                     input logic [PosWidth-1:0] start);
      mask_request_type item;
      item.opcode     = op;
      item.word_index = idx;
      item.word_data  = data;
      item.start_bit  = start;
      return item;
   endfunction

   // mostly empty or sparse words so that searches skip far
   function automatic logic [63:0] pick_word();
      logic [63:0] a;
      a = {$urandom, $urandom};
      case ($urandom_range(9))
         0, 1, 2, 3: return '0;
         4, 5:       return 64'd1 << $urandom_range(63);
         6:          return a;
         7:          return a & {$urandom, $urandom} & {$urandom, $urandom};
         8:          return '1;
         default:    return ~(64'd1 << $urandom_range(63));
      endcase
   endfunction

   // start positions: inside the size, on word edges, near the size, anywhere
   function automatic logic [PosWidth-1:0] pick_start(input logic [PosWidth-1:0] sz);
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return PosWidth'($urandom_range(sz));
         5, 6:          return PosWidth'($urandom_range(15) * 64 +
                                         ($urandom_range(1) ? 63 : 0));
         7:             return PosWidth'($urandom_range(2047));
         8:             return (sz >= 2) ? sz - PosWidth'($urandom_range(2)) : sz;
         default:       return sz;
      endcase
   endfunction

   // offer one word, idling at random, and hold it until taken
   task automatic offer_request(input mask_request_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= item.opcode;
      req_word_index <= item.word_index;
      req_word_data  <= item.word_data;
      req_start_bit  <= item.start_bit;
      do @(posedge clock); while (req_stall !== 1'b0);
      predictor.note_request(item);
   endtask

   // drop valid, wait for every pending result, then let a trailing write settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (predictor.expected_finds.size() != 0) @(posedge clock);
      repeat (SettleWait) @(posedge clock);
   endtask

   task automatic write_size(input logic [PosWidth-1:0] v);
      drain();
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_bits_in_use <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      predictor.set_size(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [PosWidth-1:0] sizes [6];
      mask_request_type    item;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // size zero after reset: nothing can be found
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd0));
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd2047));

      // full size: empty store, skips across empty words, edges
      write_size(11'd1024);
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd0));
      offer_request(make_request(OP_WRITE, 4'd15, 64'h8000_0000_0000_0000, 11'd0));
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd0));
      offer_request(make_request(OP_WRITE, 4'd0, 64'h1, 11'd0));
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd0));
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd1));
      offer_request(make_request(OP_WRITE, 4'd7, '1, 11'd0));
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd1));
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd1023));
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd1024));
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd2047));
      offer_request(make_request(OP_WRITE, 4'd3, 64'h1_0000_0000, 11'd0));
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd200));
      offer_request(make_request(OP_WRITE, 4'd15, '0, 11'd0));
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd500));
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd512));

      // short size: bits set above it are never reported
      write_size(11'd460);
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd455));
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd460));
      offer_request(make_request(OP_WRITE, 4'd7, 64'h8000_0000_0000_0000, 11'd0));
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd300));

      // oversized write clamps to the store
      write_size(11'd2047);
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd0));
      offer_request(make_request(OP_FIND, 4'd0, '0, 11'd1));

      // random phases, one size each
      sizes = '{11'd64, 11'd1, 11'd1024, 11'd2047, 11'd700, PosWidth'($urandom_range(2047))};
      foreach (sizes[p]) begin
         write_size(sizes[p]);
         send_idle_pct = (p == 1) ? 0 : 20;
         rsp_idle_pct  = (p == 1) ? 0 : 20;
         for (int n = 0; n < PhaseItems; n++) begin
            // back up the result side while finds keep coming
            if (p == 2 && n == 5) begin
               @(posedge clock);
               rsp_hold_left = HoldOffLong;
            end
            item.opcode     = ($urandom_range(99) < 30) ? OP_WRITE : OP_FIND;
            item.word_index = 4'($urandom_range(15));
            item.word_data  = pick_word();
            item.start_bit  = pick_start(predictor.size_bits);
            offer_request(item);
         end
      end

      drain();
      if (predictor.errors == 0)
         $display("PASS bitmask_find_next_set_unit");
      else
         $display("FAIL bitmask_find_next_set_unit");
      $finish;
   end

endmodule

>>> sim.f
design/bmfns_pkg.sv
design/bmfns_ctrl.sv
design/bmfns_dpath.sv
design/bitmask_find_next_set_unit.sv
tb/tb_bitmask_find_next_set_unit.sv
